// ----- rtl/wsp_pkg.sv -----
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared operation codes, pattern byte constants and the control bundle
// passed from the top level to the token store and the NFA.
// ----------------------------------------------------------------------------
package wsp_pkg;

  // Operation carried in tuser with each input transaction
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_TEXT   = 2'd1,
    OP_REPORT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  localparam logic [7:0] WILD_BYTE = 8'h2E;  // '.'
  localparam logic [7:0] STAR_BYTE = 8'h2A;  // '*'

  // One-hot strobes for the item being executed this cycle
  typedef struct packed {
    logic append;
    logic text;
    logic report;
    logic clear;
  } ctrl_t;

endpackage

// ----- rtl/wsp_token_store.sv -----
// ----------------------------------------------------------------------------
// wsp_token_store
// Pattern token store: one byte and one star flag per token, token count and
// the sticky overflow flag. Compares the current byte against every token.
// ----------------------------------------------------------------------------
module wsp_token_store import wsp_pkg::*; #(
  parameter int MAX_TOKENS = 32,
  parameter int CntW       = $clog2(MAX_TOKENS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  input  logic [7:0]            char_i,
  output logic [MAX_TOKENS-1:0] hit_o,
  output logic [MAX_TOKENS-1:0] star_o,
  output logic [CntW-1:0]       count_o,
  output logic                  ovf_o
);

  logic [7:0]            tok_byte_q [MAX_TOKENS];
  logic [MAX_TOKENS-1:0] tok_star_q;
  logic [MAX_TOKENS-1:0] valid;
  logic [CntW-1:0]       count_q, count_d;
  logic                  ovf_q, ovf_d;
  logic                  last_starred;
  logic                  is_star;
  logic                  do_star;
  logic                  do_lit;
  logic                  full;

  // Per-token valid mask and match against the current byte
  always_comb begin
    for (int k = 0; k < MAX_TOKENS; k++) begin
      valid[k] = (count_q > CntW'(k));
      hit_o[k] = valid[k] & ((tok_byte_q[k] == char_i) | (tok_byte_q[k] == WILD_BYTE));
      star_o[k] = valid[k] & tok_star_q[k];
    end
  end

  // Star flag of the most recent token
  always_comb begin
    last_starred = 1'b0;
    for (int k = 0; k < MAX_TOKENS; k++) begin
      last_starred = last_starred | ((count_q == CntW'(k + 1)) & tok_star_q[k]);
    end
  end

  // Decode an append: star the last token, add a literal, or overflow
  assign full    = (count_q == CntW'(MAX_TOKENS));
  assign is_star = (char_i == STAR_BYTE);
  assign do_star = ctrl_i.append & is_star & (count_q != '0) & ~last_starred;
  assign do_lit  = ctrl_i.append & ~do_star & ~full;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (ctrl_i.clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (do_lit) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.append && !do_star) begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // Write token entries; contents are undefined until written
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_TOKENS; k++) begin
      if (do_lit && (count_q == CntW'(k))) begin
        tok_byte_q[k] <= char_i;
        tok_star_q[k] <= 1'b0;
      end else if (do_star && (count_q == CntW'(k + 1))) begin
        tok_star_q[k] <= 1'b1;
      end
    end
  end

  assign count_o = count_q;
  assign ovf_o   = ovf_q;

endmodule

// ----- rtl/wsp_nfa.sv -----
// ----------------------------------------------------------------------------
// wsp_nfa
// Bit-parallel NFA active set. Star closure runs through a log-depth prefix
// network; a text byte moves each live position along or keeps it on a star.
// ----------------------------------------------------------------------------
module wsp_nfa import wsp_pkg::*; #(
  parameter int MAX_TOKENS = 32,
  parameter int CntW       = $clog2(MAX_TOKENS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  input  logic [MAX_TOKENS-1:0] hit_i,
  input  logic [MAX_TOKENS-1:0] star_i,
  input  logic [CntW-1:0]       count_i,
  output logic                  accept_o
);

  localparam int N    = MAX_TOKENS + 1;
  localparam int Lvls = $clog2(N);

  logic [N-1:0] active_q, active_d;
  logic [N-1:0] gen [Lvls+1];
  logic [N-1:0] prp [Lvls+1];
  logic [N-1:0] closed;
  logic [N-1:0] next_set;
  logic [N-1:0] start_set;

  assign start_set = N'(1);

  // Star closure: a set position flows forward across a run of starred tokens
  always_comb begin
    gen[0]    = active_q;
    prp[0][0] = 1'b0;
    for (int i = 1; i < N; i++) begin
      prp[0][i] = star_i[i-1];
    end
    for (int l = 0; l < Lvls; l++) begin
      for (int i = 0; i < N; i++) begin
        if (i >= (1 << l)) begin
          gen[l+1][i] = gen[l][i] | (prp[l][i] & gen[l][i-(1<<l)]);
          prp[l+1][i] = prp[l][i] & prp[l][i-(1<<l)];
        end else begin
          gen[l+1][i] = gen[l][i];
          prp[l+1][i] = prp[l][i];
        end
      end
    end
    closed = gen[Lvls];
  end

  // Advance on a text byte: starred tokens hold, plain tokens step forward
  always_comb begin
    next_set = '0;
    for (int k = 0; k < MAX_TOKENS; k++) begin
      next_set[k]   = next_set[k] | (closed[k] & hit_i[k] & star_i[k]);
      next_set[k+1] = next_set[k+1] | (closed[k] & hit_i[k] & ~star_i[k]);
    end
  end

  // Accept when the position just past the last token is live
  always_comb begin
    accept_o = 1'b0;
    for (int k = 0; k < N; k++) begin
      accept_o = accept_o | (closed[k] & (count_i == CntW'(k)));
    end
  end

  always_comb begin
    active_d = active_q;
    if (ctrl_i.text) begin
      active_d = next_set;
    end else if (ctrl_i.append || ctrl_i.report || ctrl_i.clear) begin
      active_d = start_set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= start_set;
    end else begin
      active_q <= active_d;
    end
  end

endmodule

// ----- rtl/wildcard_star_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// wildcard_star_pattern_matcher
// Full-string matcher for patterns with '.' and 'x*', pattern loaded by byte,
// text streamed by byte, result on an end-of-text transaction.
// ----------------------------------------------------------------------------
// Result path: a report's result reaches m_axis via the input register, then the
// result register. Throughput: one transaction per cycle unless a report waits
// on a stalled result; the NFA step and star closure of one byte fit between
// the input register and the state/result registers.
// Reset: empty pattern, overflow clear, active set at the start position only.
module wildcard_star_pattern_matcher import wsp_pkg::*; #(
  parameter int MAX_TOKENS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] character
  input  logic [1:0] s_axis_tuser,   // [1:0] operation
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

  localparam int CntW = $clog2(MAX_TOKENS + 1);

  logic                  in_valid_q, in_valid_d;
  op_e                   op_q;
  logic [7:0]            char_q;
  logic                  advance;
  logic                  s_fire;
  ctrl_t                 ctrl;
  logic [MAX_TOKENS-1:0] hit;
  logic [MAX_TOKENS-1:0] star;
  logic [CntW-1:0]       count;
  logic                  ovf;
  logic                  accept;
  logic                  out_valid_q, out_valid_d;
  logic                  matched_q;
  logic                  ovf_q;

  // Execute the held transaction unless a report is blocked by a full result
  assign advance = in_valid_q &
                   ~((op_q == OP_REPORT) & out_valid_q & ~m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Capture payload of an accepted transaction
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q   <= op_e'(s_axis_tuser);
      char_q <= s_axis_tdata;
    end
  end

  // Decode strobes for this cycle
  always_comb begin
    ctrl.append = advance & (op_q == OP_APPEND);
    ctrl.text   = advance & (op_q == OP_TEXT);
    ctrl.report = advance & (op_q == OP_REPORT);
    ctrl.clear  = advance & (op_q == OP_CLEAR);
  end

  wsp_token_store #(
    .MAX_TOKENS (MAX_TOKENS),
    .CntW       (CntW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .char_i  (char_q),
    .hit_o   (hit),
    .star_o  (star),
    .count_o (count),
    .ovf_o   (ovf)
  );

  wsp_nfa #(
    .MAX_TOKENS (MAX_TOKENS),
    .CntW       (CntW)
  ) u_nfa (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .hit_i    (hit),
    .star_i   (star),
    .count_i  (count),
    .accept_o (accept)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.report) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.report) begin
      matched_q <= accept & ~ovf;
      ovf_q     <= ovf;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, ovf_q, matched_q};

endmodule

// ----- rtl/wsp_checker.sv -----
// ----------------------------------------------------------------------------
// wsp_checker
// Port-level checks for the pattern matcher, bound to the top level.
// ----------------------------------------------------------------------------
module wsp_checker import wsp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // A match is never reported with the overflow flag set
  a_no_match_on_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("match reported on overflowed pattern");

  // An accepted report transaction must show a result on m_axis
  a_report_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_REPORT)
      |=> ##1 m_axis_tvalid)
    else $error("report produced no result");

endmodule

bind wildcard_star_pattern_matcher wsp_checker u_wsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wildcard-star pattern matcher. Pattern loads,
// text bytes, reports and clears are streamed into s_axis; a local predictor
// of the token store and NFA active set computes each report, and every
// m_axis transaction is compared against the oldest outstanding report.
// ----------------------------------------------------------------------------
module testbench;
  import wsp_pkg::*;

  localparam int MAX_TOK     = 32;
  localparam int HALF_ITEMS  = 800;
  localparam int TOTAL_ITEMS = 1550;
  localparam logic [MAX_TOK:0] START_SET = {{MAX_TOK{1'b0}}, 1'b1};

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } stream_item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } match_result_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] character
  logic [1:0] s_axis_tuser  = OP_TEXT; // [1:0] operation
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [0] matched, [1] pattern_overflow, [7:2] zero

  // Stimulus waiting for the driver and reports waiting for their result
  stream_item_t  item_q[$];
  match_result_t report_q[$];

  int mismatch_count = 0;
  int result_count   = 0;
  int accepted_count = 0;
  int gen_count      = 0;

  // Long stretch with no idling on either side
  wire steady = (accepted_count >= 300) && (accepted_count < 500);

  // Predictor state: token store, active set, overflow flag
  logic [7:0]       pat_byte [MAX_TOK];
  logic             pat_star [MAX_TOK];
  logic [5:0]       pat_count    = '0;
  logic [MAX_TOK:0] live_set     = START_SET;
  logic             pat_overflow = 1'b0;

  // Generator's view of the pattern it has loaded
  logic [7:0] gen_byte[$];
  logic       gen_star[$];
  logic       gen_dirty = 1'b0;

  wildcard_star_pattern_matcher #(.MAX_TOKENS(MAX_TOK)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Propagate the active set through starred tokens
  function automatic logic [MAX_TOK:0] close_stars(input logic [MAX_TOK:0] set);
    for (int k = 0; k < MAX_TOK; k++) begin
      if (k < int'(pat_count) && set[k] && pat_star[k]) set[k+1] = 1'b1;
    end
    return set;
  endfunction

  // Advance the predicted matcher by one accepted transaction
  task automatic track_item(input op_e op, input logic [7:0] ch);
    logic [MAX_TOK:0] live;
    logic [MAX_TOK:0] nxt;
    match_result_t    res;
    case (op)
      OP_APPEND: begin
        if (ch == STAR_BYTE && pat_count != 0 && !pat_star[pat_count[4:0] - 5'd1]) begin
          pat_star[pat_count[4:0] - 5'd1] = 1'b1;
        end else if (pat_count < MAX_TOK) begin
          pat_byte[pat_count[4:0]] = ch;
          pat_star[pat_count[4:0]] = 1'b0;
          pat_count++;
        end else begin
          pat_overflow = 1'b1;
        end
        live_set = START_SET;
      end
      OP_TEXT: begin
        live = close_stars(live_set);
        nxt  = '0;
        for (int k = 0; k < MAX_TOK; k++) begin
          if (k < int'(pat_count) && live[k] &&
              (pat_byte[k] == ch || pat_byte[k] == WILD_BYTE)) begin
            if (pat_star[k]) nxt[k] = 1'b1;
            else nxt[k+1] = 1'b1;
          end
        end
        live_set = nxt;
      end
      OP_REPORT: begin
        live         = close_stars(live_set);
        res.matched  = live[pat_count] && !pat_overflow;
        res.overflow = pat_overflow;
        report_q.push_back(res);
        live_set = START_SET;
      end
      default: begin
        pat_count    = '0;
        pat_overflow = 1'b0;
        live_set     = START_SET;
      end
    endcase
  endtask

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR: result %0d: %s", result_count, what);
  endtask

  task automatic emit(input op_e op, input logic [7:0] ch);
    stream_item_t it;
    it.op = op;
    it.ch = ch;
    item_q.push_back(it);
    gen_count++;
  endtask

  // One sequence: random noise, or optional clear, pattern tokens, then text/report rounds
  task automatic gen_sequence();
    int         n;
    int         r;
    int         reps;
    int         pos;
    logic [7:0] b;
    logic       st;
    logic [7:0] txt[$];
    // occasional noise: random transactions that break the sequence
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 4)) emit(op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      gen_dirty = 1'b1;
      return;
    end
    if (gen_dirty || gen_byte.size() >= 20 || $urandom_range(0, 99) < 40) begin
      emit(OP_CLEAR, 8'($urandom_range(0, 255)));
      gen_byte.delete();
      gen_star.delete();
      gen_dirty = 1'b0;
    end
    // mostly short patterns, a few that fill or overflow the store
    n = ($urandom_range(0, 99) < 6) ? $urandom_range(31, 34) : $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r <= 3) b = "a";
      else if (r <= 5) b = "b";
      else if (r <= 7) b = WILD_BYTE;
      else if (r == 8) b = 8'($urandom_range(0, 255));
      else b = STAR_BYTE;
      // a literal star only where it cannot star the previous token
      if (b == STAR_BYTE && gen_byte.size() != 0 && !gen_star[$]) b = "c";
      st = ($urandom_range(0, 2) == 0);
      emit(OP_APPEND, b);
      if (st) emit(OP_APPEND, STAR_BYTE);
      gen_byte.push_back(b);
      gen_star.push_back(st);
    end
    // text built from the pattern, sometimes corrupted
    repeat ($urandom_range(1, 3)) begin
      txt.delete();
      for (int k = 0; k < gen_byte.size() && k < MAX_TOK; k++) begin
        reps = gen_star[k] ? $urandom_range(0, 3) : 1;
        repeat (reps) txt.push_back(gen_byte[k] == WILD_BYTE ? 8'($urandom_range(0, 255))
                                                             : gen_byte[k]);
      end
      if ($urandom_range(0, 99) < 30) begin
        r = $urandom_range(0, 2);
        if (txt.size() == 0 || r == 2) begin
          pos = $urandom_range(0, txt.size());
          txt.insert(pos, 8'($urandom_range(0, 255)));
        end else begin
          pos = $urandom_range(0, txt.size() - 1);
          if (r == 0) txt[pos] = 8'($urandom_range(0, 255));
          else txt.delete(pos);
        end
      end
      foreach (txt[i]) emit(OP_TEXT, txt[i]);
      emit(OP_REPORT, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_drained();
    while (item_q.size() != 0 || s_axis_tvalid || report_q.size() != 0) @(posedge clk_i);
  endtask

  // Drive the next pending transaction once the current one is taken
  always @(posedge clk_i) begin : drive
    stream_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (item_q.size() != 0 && (steady || $urandom_range(0, 99) >= 19)) begin
        nxt = item_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.op;
        s_axis_tdata  <= nxt.ch;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && (steady || $urandom_range(0, 99) >= 19);
  end

  // Check results, then feed accepted input to the predictor
  always @(posedge clk_i) begin : watch
    match_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_count++;
        if (report_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result, tdata %h", m_axis_tdata));
        end else begin
          want = report_q.pop_front();
          if (m_axis_tdata[0] !== want.matched)
            flag_mismatch($sformatf("matched expected %b got %b", want.matched,
                                    m_axis_tdata[0]));
          if (m_axis_tdata[1] !== want.overflow)
            flag_mismatch($sformatf("pattern_overflow expected %b got %b", want.overflow,
                                    m_axis_tdata[1]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        track_item(op_e'(s_axis_tuser), s_axis_tdata);
        accepted_count++;
      end
    end
  end

  // Stimulus
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty pattern against empty and non-empty text
    emit(OP_REPORT, 8'h00);
    emit(OP_TEXT,   8'hFF);
    emit(OP_REPORT, 8'h00);
    // leading star, starred literal star, wildcard star, doubled star
    emit(OP_APPEND, STAR_BYTE);
    emit(OP_APPEND, STAR_BYTE);
    emit(OP_APPEND, 8'h00);
    emit(OP_APPEND, WILD_BYTE);
    emit(OP_APPEND, STAR_BYTE);
    emit(OP_APPEND, STAR_BYTE);
    emit(OP_TEXT,   STAR_BYTE);
    emit(OP_TEXT,   STAR_BYTE);
    emit(OP_TEXT,   8'h00);
    emit(OP_TEXT,   8'hFF);
    emit(OP_TEXT,   8'h55);
    emit(OP_TEXT,   STAR_BYTE);
    emit(OP_REPORT, 8'hFF);
    emit(OP_REPORT, 8'hFF);
    // pattern change in the middle of the text, then clear
    emit(OP_TEXT,   8'h00);
    emit(OP_APPEND, 8'hAA);
    emit(OP_CLEAR,  8'hAA);
    emit(OP_APPEND, 8'hFF);
    emit(OP_TEXT,   8'hFF);
    emit(OP_REPORT, 8'h00);
    emit(OP_CLEAR,  8'hFF);
    emit(OP_REPORT, 8'h00);
    gen_dirty = 1'b1;
    wait_drained();

    // random sequences, with a full drain between the two halves
    while (gen_count < HALF_ITEMS) gen_sequence();
    wait_drained();
    while (gen_count < TOTAL_ITEMS) gen_sequence();
    wait_drained();
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
